// ----- hw/rtl/pba_pkg.sv -----
// ----------------------------------------------------------------------------
// pba_pkg
// Types and constants shared by the page block allocator modules.
// ----------------------------------------------------------------------------
package pba_pkg;

	localparam int SLOT_COUNT_DEF   = 16;
	localparam int MEMORY_BYTES_DEF = 16777216;

	localparam int PAGES_W  = 21;
	localparam int HANDLE_W = 32;
	localparam int ADDR_W   = 25;
	localparam int PAGE_SHIFT = 12;
	// end address at full width: base plus pages << PAGE_SHIFT never wraps
	localparam int END_W    = PAGES_W + PAGE_SHIFT + 1;

	localparam logic [ADDR_W:0]   PAGE_MASK   = (ADDR_W+1)'(12'hFFF);
	localparam logic [ADDR_W-1:0] BREAK_RESET = ADDR_W'(32'h0010_0000);
	localparam logic [HANDLE_W-1:0] HANDLE_RESET = HANDLE_W'(1);

	typedef enum logic {
		MODE_ALLOC = 1'b0,
		MODE_FREE  = 1'b1
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_ZERO_PAGES = 2'd1,
		ST_NO_MEMORY  = 2'd2,
		ST_UNKNOWN    = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_SCAN,
		FSM_HOLD
	} fsm_t;

	typedef struct packed {
		mode_t               mode;
		logic [PAGES_W-1:0]  page_count;
		logic [HANDLE_W-1:0] free_handle;
	} req_t;

	typedef struct packed {
		status_t             status;
		logic [ADDR_W-1:0]   linear_base;
		logic [HANDLE_W-1:0] block_handle;
		logic [ADDR_W-1:0]   free_bytes;
	} rsp_t;

	// token that walks the slot chain, one cell per cycle
	typedef struct packed {
		logic active;
		logic hit;
	} token_t;

	// request held steady while the token walks the chain
	typedef struct packed {
		mode_t               mode;
		logic [HANDLE_W-1:0] key;
		logic [HANDLE_W-1:0] new_handle;
	} cmd_t;

endpackage

// ----- hw/rtl/pba_stream_if.sv -----
// ----------------------------------------------------------------------------
// pba_stream_if
// Valid/ready channel carrying one payload of type T per transfer.
// ----------------------------------------------------------------------------
interface pba_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/pba_cell.sv -----
// ----------------------------------------------------------------------------
// pba_cell
// One handle table slot. Claims or releases itself when the token passes.
// ----------------------------------------------------------------------------
module pba_cell
	import pba_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  cmd_t   cmd,
	input  token_t token_in,
	output token_t token_out
);

	logic                used_q;
	logic [HANDLE_W-1:0] handle_q;
	token_t              token_q;
	logic                live;
	logic                claim;
	logic                release_slot;

	assign live         = token_in.active && !token_in.hit;
	assign claim        = live && (cmd.mode == MODE_ALLOC) && !used_q;
	assign release_slot = live && (cmd.mode == MODE_FREE) && used_q &&
	                      (handle_q == cmd.key);
	assign token_out    = token_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q  <= 1'b0;
			token_q <= '0;
		end else begin
			if (claim) begin
				used_q <= 1'b1;
			end else if (release_slot) begin
				used_q <= 1'b0;
			end
			token_q.active <= token_in.active;
			token_q.hit    <= token_in.hit || claim || release_slot;
		end
	end

	always_ff @(posedge clk) begin
		if (claim) begin
			handle_q <= cmd.new_handle;
		end
	end

endmodule

// ----- hw/rtl/page_block_allocator.sv -----
// Path: zero-page or oversize allocate requests go straight to the hold
//   state; other requests pass the launch register and every slot cell.
// Throughput: one request at a time; the token walks the slot chain one cell
//   per cycle, and a request occupies the block until its response is loaded.
// Reset: arst_n returns break to 0x100000 and handle counter to one, and clears
//   slot flags and all valid state.
// ----------------------------------------------------------------------------
// page_block_allocator
// Bump-pointer page allocator with a handle table built as a chain of cells.
// ----------------------------------------------------------------------------
module page_block_allocator
	import pba_pkg::*;
#(
	parameter int SLOT_COUNT   = SLOT_COUNT_DEF,
	parameter int MEMORY_BYTES = MEMORY_BYTES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	pba_stream_if.sink    req,
	pba_stream_if.source  rsp
);

	localparam logic [END_W-1:0]  MemEnd  = END_W'(MEMORY_BYTES);
	localparam logic [ADDR_W:0]   MemSize = (ADDR_W+1)'(MEMORY_BYTES);

	fsm_t                state_q, state_nxt;
	logic [ADDR_W-1:0]   brk_q;
	logic [HANDLE_W-1:0] next_handle_q;
	cmd_t                cmd_q;
	logic [ADDR_W-1:0]   base_q;
	logic [ADDR_W-1:0]   end_q;
	logic                launch_q;
	status_t             pend_status_q;
	logic [ADDR_W-1:0]   pend_base_q;
	logic [HANDLE_W-1:0] pend_handle_q;
	rsp_t                rsp_q;
	logic                rsp_valid_q;

	token_t              chain [SLOT_COUNT+1];

	req_t                req_data;
	logic [ADDR_W:0]     base_c;
	logic [END_W-1:0]    end_c;
	logic                fits;
	logic                zero_pages;
	logic                need_scan;
	logic                accept;
	logic                scan_done;
	logic                load_rsp;
	logic [ADDR_W:0]     free_c;

	assign req_data = req.data;

	// round the break up to a page, then form the end address at full width
	assign base_c     = ({1'b0, brk_q} + PAGE_MASK) & ~PAGE_MASK;
	assign end_c      = END_W'(base_c) +
	                    END_W'({req_data.page_count, {PAGE_SHIFT{1'b0}}});
	assign fits       = (end_c <= MemEnd);
	assign zero_pages = (req_data.page_count == '0);
	assign need_scan  = (req_data.mode == MODE_FREE) || (!zero_pages && fits);

	assign scan_done = chain[SLOT_COUNT].active;
	assign free_c    = (MemSize > {1'b0, brk_q}) ? (MemSize - {1'b0, brk_q}) : '0;

	// ---- next state ----
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			FSM_IDLE: begin
				if (req.valid) begin
					state_nxt = need_scan ? FSM_SCAN : FSM_HOLD;
				end
			end
			FSM_SCAN: begin
				if (scan_done) begin
					state_nxt = FSM_HOLD;
				end
			end
			FSM_HOLD: begin
				if (!rsp_valid_q || rsp.ready) begin
					state_nxt = FSM_IDLE;
				end
			end
			default: state_nxt = FSM_IDLE;
		endcase
	end

	// ---- outputs ----
	always_comb begin
		req.ready = 1'b0;
		load_rsp  = 1'b0;
		unique case (state_q)
			FSM_IDLE: req.ready = 1'b1;
			FSM_SCAN: ;
			FSM_HOLD: load_rsp = !rsp_valid_q || rsp.ready;
			default: ;
		endcase
	end

	assign accept = req.valid && req.ready;

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	// ---- slot chain ----
	assign chain[0].active = launch_q;
	assign chain[0].hit    = 1'b0;

	for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
		pba_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd_q),
			.token_in  (chain[i]),
			.token_out (chain[i+1])
		);
	end

	// ---- control registers ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= FSM_IDLE;
			brk_q         <= BREAK_RESET;
			next_handle_q <= HANDLE_RESET;
			launch_q      <= 1'b0;
			rsp_valid_q   <= 1'b0;
		end else begin
			state_q  <= state_nxt;
			launch_q <= accept && need_scan;
			// advance break and handle counter on a successful claim
			if (state_q == FSM_SCAN && scan_done && chain[SLOT_COUNT].hit &&
			    cmd_q.mode == MODE_ALLOC) begin
				brk_q         <= end_q;
				next_handle_q <= next_handle_q + HANDLE_W'(1);
			end
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// ---- payload registers ----
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q.mode       <= req_data.mode;
			cmd_q.key        <= req_data.free_handle;
			cmd_q.new_handle <= next_handle_q;
			base_q           <= base_c[ADDR_W-1:0];
			end_q            <= end_c[ADDR_W-1:0];
			pend_base_q      <= '0;
			pend_handle_q    <= '0;
			if (req_data.mode == MODE_ALLOC && zero_pages) begin
				pend_status_q <= ST_ZERO_PAGES;
			end else begin
				pend_status_q <= ST_NO_MEMORY;
			end
		end else if (state_q == FSM_SCAN && scan_done) begin
			if (chain[SLOT_COUNT].hit) begin
				pend_status_q <= ST_OK;
				if (cmd_q.mode == MODE_ALLOC) begin
					pend_base_q   <= base_q;
					pend_handle_q <= cmd_q.new_handle;
				end
			end else if (cmd_q.mode == MODE_FREE) begin
				pend_status_q <= ST_UNKNOWN;
			end else begin
				pend_status_q <= ST_NO_MEMORY;
			end
		end

		if (load_rsp) begin
			rsp_q.status       <= pend_status_q;
			rsp_q.linear_base  <= pend_base_q;
			rsp_q.block_handle <= pend_handle_q;
			rsp_q.free_bytes   <= free_c[ADDR_W-1:0];
		end
	end

endmodule
